[hdl/npd_pkg.sv]
// Shared types and constants for the nested priority task dispatcher.
// Holds function codes, result status codes and the cell operation types.
// No dependencies.
package npd_pkg;

  // Fixed field widths of the transaction ports.
  localparam int FUNC_W     = 2;
  localparam int IN_PRIO_W  = 8;
  localparam int ID_W       = 8;
  localparam int STATUS_W   = 3;
  localparam int OUT_PRIO_W = 8;
  localparam int OUT_LVL_W  = 9;
  localparam int OUT_CNT_W  = 5;

  // Function codes carried on in_func.
  localparam logic [FUNC_W-1:0] FUNC_ENQUEUE  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DISPATCH = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_COMPLETE = 2'd2;

  // Result status codes carried on out_status.
  localparam logic [STATUS_W-1:0] ST_ENQUEUED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL       = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DISPATCHED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NONE       = 3'd3;
  localparam logic [STATUS_W-1:0] ST_COMPLETED  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NOTHING    = 3'd5;

  // Operation broadcast to every queue cell in a cycle.
  typedef enum logic [1:0] {
    Q_HOLD,
    Q_INSERT,
    Q_SHIFT_OUT
  } qop_t;

  // Operation broadcast to every level stack cell in a cycle.
  typedef enum logic [1:0] {
    S_HOLD,
    S_PUSH,
    S_POP
  } sop_t;

endpackage

[hdl/npd_queue_cell.sv]
// One entry of the sorted pending-task queue.
// Depends on npd_pkg for the queue operation type.
// Inserts based on its own compare and its left neighbor, shifts in its right neighbor's entry, or holds.
module npd_queue_cell #(
  parameter int PRIO_W = 8
) (
  input  logic                    clk,
  input  npd_pkg::qop_t           op,
  input  logic                    occupied,
  input  logic                    left_stays,
  input  logic [PRIO_W-1:0]       left_prio,
  input  logic [npd_pkg::ID_W-1:0] left_id,
  input  logic [PRIO_W-1:0]       right_prio,
  input  logic [npd_pkg::ID_W-1:0] right_id,
  input  logic [PRIO_W-1:0]       new_prio,
  input  logic [npd_pkg::ID_W-1:0] new_id,
  output logic                    stays,
  output logic [PRIO_W-1:0]       prio,
  output logic [npd_pkg::ID_W-1:0] id
);
  import npd_pkg::*;

  logic [PRIO_W-1:0] prio_r;
  logic [ID_W-1:0]   id_r;

  // An occupied entry of equal or more urgent priority stays ahead of a new task.
  assign stays = occupied && (prio_r <= new_prio);
  assign prio  = prio_r;
  assign id    = id_r;

  always_ff @(posedge clk) begin
    unique case (op)
      Q_INSERT: begin
        if (!stays) begin
          if (left_stays) begin
            prio_r <= new_prio;
            id_r   <= new_id;
          end else begin
            prio_r <= left_prio;
            id_r   <= left_id;
          end
        end
      end
      Q_SHIFT_OUT: begin
        prio_r <= right_prio;
        id_r   <= right_id;
      end
      default: begin
        prio_r <= prio_r;
        id_r   <= id_r;
      end
    endcase
  end

endmodule

[hdl/npd_stack_cell.sv]
// One entry of the preempted-level stack, kept as a shift chain with its top at cell zero.
// Depends on npd_pkg for the stack operation type.
module npd_stack_cell #(
  parameter int LEVEL_W = 9
) (
  input  logic               clk,
  input  npd_pkg::sop_t      op,
  input  logic [LEVEL_W-1:0] push_level,
  input  logic [LEVEL_W-1:0] pop_level,
  output logic [LEVEL_W-1:0] level
);
  import npd_pkg::*;

  logic [LEVEL_W-1:0] level_r;

  assign level = level_r;

  always_ff @(posedge clk) begin
    unique case (op)
      S_PUSH:  level_r <= push_level;
      S_POP:   level_r <= pop_level;
      default: level_r <= level_r;
    endcase
  end

endmodule

[hdl/nested_priority_task_dispatcher_unit.sv]
// Top level of the nested priority task dispatcher.
// Depends on npd_pkg, npd_queue_cell and npd_stack_cell.
// Holds the fill and nesting counters, the running level and the result register.
module nested_priority_task_dispatcher_unit #(
  parameter int QUEUE_DEPTH = 16,
  parameter int NEST_DEPTH  = 16,
  parameter int PRIO_BITS   = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [npd_pkg::FUNC_W-1:0]    in_func,
  input  logic [npd_pkg::IN_PRIO_W-1:0] in_task_priority,
  input  logic [npd_pkg::ID_W-1:0]      in_task_id,
  output logic                          out_valid,
  output logic [npd_pkg::STATUS_W-1:0]  out_status,
  output logic [npd_pkg::ID_W-1:0]      out_task_id,
  output logic [npd_pkg::OUT_PRIO_W-1:0] out_priority,
  output logic [npd_pkg::OUT_LVL_W-1:0] out_running_level,
  output logic [npd_pkg::OUT_CNT_W-1:0] out_pending_count
);
  // This block keeps a queue of pending tasks sorted by priority (smaller is more
  // urgent, equal priorities leave in arrival order) and a stack of preempted
  // running levels. A transaction is accepted at a rising edge where start is high
  // and busy is low; busy is high during reset and clears at the first rising edge
  // after reset is released. The queue is a chain of cells that all compare their
  // entry against the new priority at once and shift left, right or hold in the
  // same cycle, and the level stack is a second chain that shifts on push and pop,
  // so a new transaction may be issued in every cycle while busy is low.
  // Exactly one result follows each transaction, on the cycle after its
  // acceptance, marked by a single cycle out_valid strobe. The receiver cannot
  // stall: a result must be captured in the cycle it is shown. The running level
  // reads as two to the power PRIO_BITS while no task runs. Only the low PRIO_BITS
  // bits of in_task_priority are used.
  import npd_pkg::*;

  localparam int PW     = PRIO_BITS;
  localparam int LVL_W  = PRIO_BITS + 1;
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int DEPTH_W = $clog2(NEST_DEPTH + 1);
  localparam logic [LVL_W-1:0] IDLE_LEVEL = {1'b1, {PW{1'b0}}};

  logic accept;

  logic               busy_r;
  logic [FILL_W-1:0]  fill_r, fill_nxt;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic [LVL_W-1:0]   level_r, level_nxt;

  logic                 out_valid_r;
  logic [STATUS_W-1:0]  status_r, status_nxt;
  logic [ID_W-1:0]      oid_r, oid_nxt;
  logic [OUT_PRIO_W-1:0] oprio_r, oprio_nxt;
  logic [OUT_LVL_W-1:0] olevel_r, olevel_nxt;
  logic [OUT_CNT_W-1:0] ocount_r, ocount_nxt;

  qop_t q_op;
  sop_t s_op;

  logic [PW+IN_PRIO_W-1:0] in_prio_ext;
  logic [PW-1:0]           new_prio;
  logic [PW+OUT_PRIO_W-1:0] head_prio_ext;
  logic [LVL_W+OUT_LVL_W-1:0] level_ext;
  logic [FILL_W+OUT_CNT_W-1:0] fill_ext;

  logic [PW-1:0]    q_prio [QUEUE_DEPTH];
  logic [ID_W-1:0]  q_id   [QUEUE_DEPTH];
  logic             q_stays [QUEUE_DEPTH];
  logic             q_occ   [QUEUE_DEPTH];
  logic [LVL_W-1:0] s_level [NEST_DEPTH];

  logic dispatch_ok;

  assign accept = start && !busy_r;
  assign busy   = busy_r;

  // Priorities are taken modulo two to the power PRIO_BITS.
  assign in_prio_ext = {{PW{1'b0}}, in_task_priority};
  assign new_prio    = in_prio_ext[PW-1:0];

  // Queue chain: cell zero is the head. Cell zero sees a left neighbor that always
  // stays, so an insert in front of everything lands there.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_queue
    logic          left_stays;
    logic [PW-1:0] left_prio;
    logic [ID_W-1:0] left_id;
    logic [PW-1:0] right_prio;
    logic [ID_W-1:0] right_id;

    assign q_occ[i] = (FILL_W'(i) < fill_r);

    if (i == 0) begin : g_first
      assign left_stays = 1'b1;
      assign left_prio  = new_prio;
      assign left_id    = in_task_id;
    end else begin : g_inner
      assign left_stays = q_stays[i-1];
      assign left_prio  = q_prio[i-1];
      assign left_id    = q_id[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_prio = q_prio[i];
      assign right_id   = q_id[i];
    end else begin : g_body
      assign right_prio = q_prio[i+1];
      assign right_id   = q_id[i+1];
    end

    npd_queue_cell #(
      .PRIO_W (PW)
    ) u_cell (
      .clk        (clk),
      .op         (q_op),
      .occupied   (q_occ[i]),
      .left_stays (left_stays),
      .left_prio  (left_prio),
      .left_id    (left_id),
      .right_prio (right_prio),
      .right_id   (right_id),
      .new_prio   (new_prio),
      .new_id     (in_task_id),
      .stays      (q_stays[i]),
      .prio       (q_prio[i]),
      .id         (q_id[i])
    );
  end

  // Level stack chain: cell zero holds the most recently preempted level.
  for (genvar j = 0; j < NEST_DEPTH; j++) begin : g_stack
    logic [LVL_W-1:0] push_level;
    logic [LVL_W-1:0] pop_level;

    if (j == 0) begin : g_top
      assign push_level = level_r;
    end else begin : g_below
      assign push_level = s_level[j-1];
    end

    if (j == NEST_DEPTH - 1) begin : g_bottom
      assign pop_level = s_level[j];
    end else begin : g_above
      assign pop_level = s_level[j+1];
    end

    npd_stack_cell #(
      .LEVEL_W (LVL_W)
    ) u_cell (
      .clk        (clk),
      .op         (s_op),
      .push_level (push_level),
      .pop_level  (pop_level),
      .level      (s_level[j])
    );
  end

  // A dispatch needs a pending head that is strictly more urgent than the running
  // level and room on the stack for the level it preempts.
  assign dispatch_ok = (fill_r != '0) && ({1'b0, q_prio[0]} < level_r) &&
                       (depth_r != DEPTH_W'(NEST_DEPTH));

  assign head_prio_ext = {{OUT_PRIO_W{1'b0}}, q_prio[0]};

  always_comb begin
    q_op       = Q_HOLD;
    s_op       = S_HOLD;
    fill_nxt   = fill_r;
    depth_nxt  = depth_r;
    level_nxt  = level_r;
    status_nxt = ST_NONE;
    oid_nxt    = '0;
    oprio_nxt  = '0;
    if (accept) begin
      unique case (in_func)
        FUNC_ENQUEUE: begin
          if (fill_r == FILL_W'(QUEUE_DEPTH)) begin
            status_nxt = ST_FULL;
          end else begin
            q_op       = Q_INSERT;
            fill_nxt   = fill_r + 1'b1;
            status_nxt = ST_ENQUEUED;
          end
        end
        FUNC_DISPATCH: begin
          if (dispatch_ok) begin
            q_op       = Q_SHIFT_OUT;
            s_op       = S_PUSH;
            fill_nxt   = fill_r - 1'b1;
            depth_nxt  = depth_r + 1'b1;
            level_nxt  = {1'b0, q_prio[0]};
            status_nxt = ST_DISPATCHED;
            oid_nxt    = q_id[0];
            oprio_nxt  = head_prio_ext[OUT_PRIO_W-1:0];
          end
        end
        FUNC_COMPLETE: begin
          if (depth_r == '0) begin
            status_nxt = ST_NOTHING;
          end else begin
            s_op       = S_POP;
            depth_nxt  = depth_r - 1'b1;
            level_nxt  = s_level[0];
            status_nxt = ST_COMPLETED;
          end
        end
        default: begin
          status_nxt = ST_NONE;
        end
      endcase
    end
  end

  assign level_ext  = {{OUT_LVL_W{1'b0}}, level_nxt};
  assign fill_ext   = {{OUT_CNT_W{1'b0}}, fill_nxt};
  assign olevel_nxt = level_ext[OUT_LVL_W-1:0];
  assign ocount_nxt = fill_ext[OUT_CNT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      fill_r      <= '0;
      depth_r     <= '0;
      level_r     <= IDLE_LEVEL;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= 1'b0;
      fill_r      <= fill_nxt;
      depth_r     <= depth_nxt;
      level_r     <= level_nxt;
      out_valid_r <= accept;
    end
  end

  // Result payload registers; they need no reset because out_valid qualifies them.
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      oid_r    <= oid_nxt;
      oprio_r  <= oprio_nxt;
      olevel_r <= olevel_nxt;
      ocount_r <= ocount_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_task_id       = oid_r;
  assign out_priority      = oprio_r;
  assign out_running_level = olevel_r;
  assign out_pending_count = ocount_r;

  // The fill count never passes the number of queue cells.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(QUEUE_DEPTH))
    else $error("pending fill exceeds queue depth");

  // The nesting depth never passes the number of stack cells.
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DEPTH_W'(NEST_DEPTH))
    else $error("nesting depth exceeds stack depth");

  // The two front entries of the queue are always in priority order.
  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    q_occ[1] |-> (q_prio[0] <= q_prio[1]))
    else $error("queue head out of priority order");

  // With nothing preempted the block must be idle.
  a_idle_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (depth_r == '0) |-> (level_r == IDLE_LEVEL))
    else $error("running level not idle with an empty stack");

  // A dispatch result reports the new running level as the dispatched priority.
  a_dispatch_level: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (status_r == ST_DISPATCHED)) |->
      (olevel_r[OUT_PRIO_W-1:0] == oprio_r))
    else $error("dispatch result level differs from dispatched priority");

endmodule
